@@ hdl/fsd_pkg.sv @@
// ----------------------------------------------------------------------------
// fsd_pkg
// shared types and constants for the fan speed hysteresis controller
// ----------------------------------------------------------------------------
package fsd_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ON_THRESHOLD    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFF_THRESHOLD   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TEMPERATURE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSITIVITY     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_MIN       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_MAX       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MANUAL_OVERRIDE = 3'd6;

   // register reset values
   localparam logic [7:0] RST_ON_THRESHOLD    = 8'd45;
   localparam logic [7:0] RST_OFF_THRESHOLD   = 8'd40;
   localparam logic [7:0] RST_MAX_TEMPERATURE = 8'd80;
   localparam logic [7:0] RST_SENSITIVITY     = 8'd2;
   localparam logic [7:0] RST_SPEED_MIN       = 8'd30;
   localparam logic [7:0] RST_SPEED_MAX       = 8'd150;

   // transaction kinds
   localparam logic OPC_SAMPLE = 1'b0;
   localparam logic OPC_SPEED  = 1'b1;

   localparam logic [7:0] DUTY_FAN_OFF = 8'd255;

   // divider geometry: dividend covers |255 * 255|, divisor covers |255|
   localparam int DIV_DIVIDEND_W = 16;
   localparam int DIV_DIVISOR_W  = 8;
   localparam int DIV_COUNT_W    = $clog2(DIV_DIVIDEND_W);

   typedef struct packed {
      logic busy;
      logic done;
   } fsd_div_status_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MUL    = 5'b00010,
      ST_START  = 5'b00100,
      ST_WAIT   = 5'b01000,
      ST_FINISH = 5'b10000
   } fsd_state_type;

endpackage

@@ hdl/fsd_divider.sv @@
// ----------------------------------------------------------------------------
// fsd_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fsd_divider
   import fsd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DIV_DIVIDEND_W-1:0] dividend,
   input  logic [DIV_DIVISOR_W-1:0]  divisor,
   output logic [DIV_DIVIDEND_W-1:0] quotient,
   output fsd_div_status_type        status
);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [DIV_COUNT_W-1:0]    count_ff, count_in;
   logic [DIV_DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIV_DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIV_DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_DIVISOR_W:0]    shifted;
   logic [DIV_DIVISOR_W:0]    trial;
   logic                      fits;

   // one restoring step: bring down the next dividend bit and try a subtract
   assign shifted = {rem_ff, quo_ff[DIV_DIVIDEND_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign fits    = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[DIV_DIVIDEND_W-2:0], fits};
         rem_in   = fits ? trial[DIV_DIVISOR_W-1:0] : shifted[DIV_DIVISOR_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_COUNT_W'(DIV_DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ hdl/fan_speed_hysteresis_control.sv @@
// ----------------------------------------------------------------------------
// fan_speed_hysteresis_control
// fan speed controller with linear temperature map and on/off hysteresis
// ----------------------------------------------------------------------------
// Each request transaction is either a temperature sample (tuser = 0) or a
// manual target speed write (tuser = 1), and yields exactly one response
// transaction carrying the PWM duty, the target speed and the write/error
// flags. Manual writes, samples outside the automatic window and samples that
// do not need the map go straight to the final state, which loads the
// response register and raises rsp_tvalid. A sample that needs the linear map
// passes through the product state, which registers the signed product, the
// start state, which loads the restoring divider, and the wait state, where
// the divider produces one quotient bit per iteration and the quotient is
// picked up, before the final state forms the response. The divider is the
// pacing unit. The block takes one transaction at a time; req_tready rises
// again once the response is loaded into the output register, so the next
// request can be accepted while that response waits. A response that is
// still waiting holds the next one in the final state until the output
// register frees up. Configuration writes are accepted in any cycle and
// should be issued only while the block is idle.
// ----------------------------------------------------------------------------
module fan_speed_hysteresis_control
   import fsd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,   // [7:0] temperature, [15:8] speed_value
   input  logic                   req_tuser,   // [0] opcode
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tdata,   // [7:0] pwm_duty, [15:8] target_speed_out
   output logic [1:0]             rsp_tuser,   // [0] pwm_write, [1] range_error
   // configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   // configuration registers
   logic [7:0] on_thr_ff, on_thr_in;
   logic [7:0] off_thr_ff, off_thr_in;
   logic [7:0] max_temp_ff, max_temp_in;
   logic [7:0] sens_ff, sens_in;
   logic [7:0] spd_min_ff, spd_min_in;
   logic [7:0] spd_max_ff, spd_max_in;
   logic       manual_ff, manual_in;

   // controller state
   logic [7:0] last_temp_ff, last_temp_in;
   logic [7:0] target_ff, target_in;
   logic [7:0] applied_ff, applied_in;
   logic [7:0] duty_ff, duty_in;

   // sequencer and work registers
   fsd_state_type      state_ff, state_in;
   logic [7:0]         temp_ff, temp_in;
   logic signed [16:0] prod_ff, prod_in;
   logic               neg_ff, neg_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_write_ff, rsp_write_in;
   logic       rsp_err_ff, rsp_err_in;
   logic [7:0] rsp_duty_ff, rsp_duty_in;
   logic [7:0] rsp_target_ff, rsp_target_in;

   // divider hookup
   logic                      div_start;
   logic [DIV_DIVIDEND_W-1:0] div_dividend;
   logic [DIV_DIVISOR_W-1:0]  div_divisor;
   logic [DIV_DIVIDEND_W-1:0] div_quotient;
   fsd_div_status_type        div_status;

   logic               req_accept;
   logic               csr_accept;
   logic               rsp_slot_free;
   logic [7:0]         req_temp;
   logic [7:0]         req_speed;
   logic [7:0]         delta;
   logic signed [8:0]  temp_ofs;
   logic signed [8:0]  spd_span;
   logic signed [8:0]  temp_span;
   logic signed [17:0] quo_signed;
   logic signed [17:0] map_sum;
   logic [7:0]         map_speed;

   assign req_temp  = req_tdata[7:0];
   assign req_speed = req_tdata[15:8];

   assign req_tready    = (state_ff == ST_IDLE);
   assign req_accept    = req_tvalid && req_tready;
   assign csr_ready     = 1'b1;
   assign csr_accept    = csr_valid && csr_ready;
   assign rsp_slot_free = !rsp_valid_ff || rsp_tready;

   // distance from the last accepted temperature
   assign delta = (req_temp >= last_temp_ff) ? (req_temp - last_temp_ff)
                                             : (last_temp_ff - req_temp);

   // linear map operands: (t - on) * (smax - smin) / (tmax - on) + smin
   assign temp_ofs  = $signed({1'b0, temp_ff}) - $signed({1'b0, on_thr_ff});
   assign spd_span  = $signed({1'b0, spd_max_ff}) - $signed({1'b0, spd_min_ff});
   assign temp_span = $signed({1'b0, max_temp_ff}) - $signed({1'b0, on_thr_ff});

   // divide magnitudes, the quotient sign is restored afterwards (truncation toward zero)
   assign div_start    = (state_ff == ST_START);
   assign div_dividend = prod_ff[16] ? DIV_DIVIDEND_W'(-prod_ff)
                                     : prod_ff[DIV_DIVIDEND_W-1:0];
   assign div_divisor  = temp_span[8] ? DIV_DIVISOR_W'(-temp_span)
                                      : temp_span[DIV_DIVISOR_W-1:0];

   assign quo_signed = neg_ff ? -$signed({2'b00, div_quotient})
                              : $signed({2'b00, div_quotient});
   assign map_sum    = quo_signed + $signed({10'd0, spd_min_ff});

   // saturate the mapped speed to a byte
   always_comb begin
      if (map_sum < 0) begin
         map_speed = 8'd0;
      end else if (map_sum > 18'sd255) begin
         map_speed = 8'd255;
      end else begin
         map_speed = map_sum[7:0];
      end
   end

   fsd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   always_comb begin
      on_thr_in     = on_thr_ff;
      off_thr_in    = off_thr_ff;
      max_temp_in   = max_temp_ff;
      sens_in       = sens_ff;
      spd_min_in    = spd_min_ff;
      spd_max_in    = spd_max_ff;
      manual_in     = manual_ff;
      last_temp_in  = last_temp_ff;
      target_in     = target_ff;
      applied_in    = applied_ff;
      duty_in       = duty_ff;
      state_in      = state_ff;
      temp_in       = temp_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_write_in  = rsp_write_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_duty_in   = rsp_duty_ff;
      rsp_target_in = rsp_target_ff;

      // configuration writes, indexes past the list are dropped
      if (csr_accept) begin
         case (csr_index)
            CSR_ON_THRESHOLD:    on_thr_in   = csr_data;
            CSR_OFF_THRESHOLD:   off_thr_in  = csr_data;
            CSR_MAX_TEMPERATURE: max_temp_in = csr_data;
            CSR_SENSITIVITY:     sens_in     = csr_data;
            CSR_SPEED_MIN:       spd_min_in  = csr_data;
            CSR_SPEED_MAX:       spd_max_in  = csr_data;
            CSR_MANUAL_OVERRIDE: manual_in   = csr_data[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               temp_in  = req_temp;
               state_in = ST_FINISH;
               if (req_tuser == OPC_SPEED) begin
                  target_in = req_speed;
               end else if (!manual_ff) begin
                  if (req_temp >= on_thr_ff && delta >= sens_ff) begin
                     last_temp_in = req_temp;
                     if (max_temp_ff == on_thr_ff) begin
                        // equal temperature limits map straight to full speed
                        target_in = spd_max_ff;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end else if (req_temp <= off_thr_ff) begin
                     target_in    = 8'd0;
                     last_temp_in = req_temp;
                  end
               end
            end
         end
         ST_MUL: begin
            // sign-extended operands keep the product exact in 17 bits
            prod_in  = $signed({{8{temp_ofs[8]}}, temp_ofs}) *
                       $signed({{8{spd_span[8]}}, spd_span});
            neg_in   = prod_in[16] ^ temp_span[8];
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_status.done) begin
               target_in = map_speed;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_slot_free) begin
               rsp_write_in = 1'b0;
               rsp_err_in   = 1'b0;
               if (target_ff != applied_ff) begin
                  if (target_ff > spd_max_ff) begin
                     rsp_err_in = 1'b1;
                  end else begin
                     duty_in      = (target_ff == 8'd0) ? DUTY_FAN_OFF
                                                        : (spd_max_ff - target_ff);
                     rsp_write_in = 1'b1;
                  end
                  applied_in = target_ff;
               end
               rsp_duty_in   = duty_in;
               rsp_target_in = target_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_thr_ff    <= RST_ON_THRESHOLD;
         off_thr_ff   <= RST_OFF_THRESHOLD;
         max_temp_ff  <= RST_MAX_TEMPERATURE;
         sens_ff      <= RST_SENSITIVITY;
         spd_min_ff   <= RST_SPEED_MIN;
         spd_max_ff   <= RST_SPEED_MAX;
         manual_ff    <= 1'b0;
         last_temp_ff <= 8'd0;
         target_ff    <= 8'd0;
         applied_ff   <= RST_SPEED_MAX;
         duty_ff      <= 8'd0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         on_thr_ff    <= on_thr_in;
         off_thr_ff   <= off_thr_in;
         max_temp_ff  <= max_temp_in;
         sens_ff      <= sens_in;
         spd_min_ff   <= spd_min_in;
         spd_max_ff   <= spd_max_in;
         manual_ff    <= manual_in;
         last_temp_ff <= last_temp_in;
         target_ff    <= target_in;
         applied_ff   <= applied_in;
         duty_ff      <= duty_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      temp_ff       <= temp_in;
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      rsp_write_ff  <= rsp_write_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_duty_ff   <= rsp_duty_in;
      rsp_target_ff <= rsp_target_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_target_ff, rsp_duty_ff};
   assign rsp_tuser  = {rsp_err_ff, rsp_write_ff};

   // the divider only runs while the sequencer waits on it
   a_div_busy_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> (state_ff == ST_WAIT))
      else $error("divider busy outside the wait state");

   // an accepted request holds off the next one: req_tready is low in the next cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request accepted while previous transaction in flight");

   // a range error never comes with a duty write
   a_err_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("range error reported together with a pwm write");

   // a write for speed zero drives the fan-off duty
   a_zero_speed_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] && rsp_tdata[15:8] == 8'd0)
         |-> (rsp_tdata[7:0] == DUTY_FAN_OFF))
      else $error("zero speed written with a duty other than fan off");

endmodule

@@ test/tb_fan_speed_hysteresis_control.sv @@
// ----------------------------------------------------------------------------
// tb_fan_speed_hysteresis_control
// self-checking bench for the fan speed controller with hysteresis
// ----------------------------------------------------------------------------
// The bench sends temperature samples and manual speed writes, with random
// gaps on the request side and random stalls on the response side. A
// scoreboard keeps its own copy of the controller state and the register
// file. For every accepted request it predicts the one response. Each
// response is then checked field by field against the oldest prediction. A
// short directed run covers the extremes and the corner cases. Random phases
// follow, each with its own register setting, and registers are only
// rewritten once the block has drained.
// ----------------------------------------------------------------------------
module tb_fan_speed_hysteresis_control;
   import fsd_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 11;
   localparam int MAX_GAP      = 17;
   localparam int STALL_LIMIT  = 4000;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 85;

   // one predicted response
   typedef struct packed {
      logic       pwm_write;
      logic [7:0] pwm_duty;
      logic [7:0] target_speed;
      logic       range_error;
   } fan_result_type;

   // controller state mirror plus the queue of predicted responses
   class fan_duty_board;
      logic [7:0]     on_thr, off_thr, max_temp, sens, spd_min, spd_max;
      logic           manual;
      logic [7:0]     last_temp, target, applied, duty;
      fan_result_type predicted_q[$];
      int             errors;

      function new();
         on_thr    = RST_ON_THRESHOLD;
         off_thr   = RST_OFF_THRESHOLD;
         max_temp  = RST_MAX_TEMPERATURE;
         sens      = RST_SENSITIVITY;
         spd_min   = RST_SPEED_MIN;
         spd_max   = RST_SPEED_MAX;
         manual    = 1'b0;
         last_temp = '0;
         target    = '0;
         applied   = RST_SPEED_MAX;
         duty      = '0;
         errors    = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [7:0] val);
         case (idx)
            CSR_ON_THRESHOLD:    on_thr   = val;
            CSR_OFF_THRESHOLD:   off_thr  = val;
            CSR_MAX_TEMPERATURE: max_temp = val;
            CSR_SENSITIVITY:     sens     = val;
            CSR_SPEED_MIN:       spd_min  = val;
            CSR_SPEED_MAX:       spd_max  = val;
            CSR_MANUAL_OVERRIDE: manual   = val[0];
            default: ;
         endcase
      endfunction

      // linear map of the temperature span onto the speed span
      function logic [7:0] linear_speed(logic [7:0] t);
         int span, num, q;
         if (max_temp == on_thr) return spd_max;
         span = int'(max_temp) - int'(on_thr);
         num  = (int'(t) - int'(on_thr)) * (int'(spd_max) - int'(spd_min));
         q    = num / span + int'(spd_min);
         if (q < 0) q = 0;
         if (q > 255) q = 255;
         return q[7:0];
      endfunction

      function void note_request(logic op, logic [7:0] t, logic [7:0] s);
         logic [7:0]     delta;
         fan_result_type r;
         r.pwm_write   = 1'b0;
         r.range_error = 1'b0;
         if (op == OPC_SPEED) begin
            target = s;
         end else if (!manual) begin
            delta = (t >= last_temp) ? t - last_temp : last_temp - t;
            if (t >= on_thr && delta >= sens) begin
               target    = linear_speed(t);
               last_temp = t;
            end else if (t <= off_thr) begin
               target    = '0;
               last_temp = t;
            end
         end
         if (target != applied) begin
            if (target > spd_max) begin
               r.range_error = 1'b1;
            end else begin
               duty        = (target == 8'd0) ? DUTY_FAN_OFF : spd_max - target;
               r.pwm_write = 1'b1;
            end
            applied = target;
         end
         r.pwm_duty     = duty;
         r.target_speed = target;
         predicted_q.push_back(r);
      endfunction

      function void check_response(logic [15:0] data, logic [1:0] flags);
         fan_result_type exp_r;
         if (predicted_q.size() == 0) begin
            $display("%0t: unexpected response, actual duty %0d speed %0d flags %b",
                     $time, data[7:0], data[15:8], flags);
            errors++;
            return;
         end
         exp_r = predicted_q.pop_front();
         if (flags[0] !== exp_r.pwm_write) begin
            $display("%0t: pwm_write mismatch, expected %0d, actual %0d",
                     $time, exp_r.pwm_write, flags[0]);
            errors++;
         end
         if (data[7:0] !== exp_r.pwm_duty) begin
            $display("%0t: pwm_duty mismatch, expected %0d, actual %0d",
                     $time, exp_r.pwm_duty, data[7:0]);
            errors++;
         end
         if (data[15:8] !== exp_r.target_speed) begin
            $display("%0t: target_speed_out mismatch, expected %0d, actual %0d",
                     $time, exp_r.target_speed, data[15:8]);
            errors++;
         end
         if (flags[1] !== exp_r.range_error) begin
            $display("%0t: range_error mismatch, expected %0d, actual %0d",
                     $time, exp_r.range_error, flags[1]);
            errors++;
         end
      endfunction

      function int outstanding();
         return predicted_q.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [15:0]            rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_data = '0;

   fan_duty_board board;
   bit            sender_burst   = 1'b0;
   bit            receiver_burst = 1'b0;
   int            idle_cycles    = 0;

   fan_speed_hysteresis_control dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] temperature, [15:8] speed_value
      .req_tuser  (req_tuser),   // [0] opcode
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] pwm_duty, [15:8] target_speed_out
      .rsp_tuser  (rsp_tuser),   // [0] pwm_write, [1] range_error
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // watchdog: too long without any transaction on any channel ends the run
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("FAIL fan_speed_hysteresis_control");
         $finish;
      end
   end

   // one request transaction; inputs move at the falling edge only
   task automatic send_request(input logic op, input logic [7:0] t,
                               input logic [7:0] s);
      int gap;
      if ($urandom_range(0, 29) == 0) sender_burst = ~sender_burst;
      gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         req_tdata  = 16'($urandom);      // junk while idle
         req_tuser  = 1'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {s, t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(op, t, s);
   endtask

   // stop sending and wait for every predicted response
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   // register writes go in only with the block idle
   task automatic settle();
      drain();
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // response side: random stalls, burst stretches with tready held high
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 29) == 0) receiver_burst = ~receiver_burst;
         stall = receiver_burst ? 0 : $urandom_range(0, MAX_GAP);
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_response(rsp_tdata, rsp_tuser);
      end
   end

   initial begin
      int         cur, pick;
      int         on_v, off_v, maxt_v, sens_v, smin_v, smax_v, man_v;
      logic [7:0] sval;
      board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed part, register reset values ----
      send_request(OPC_SAMPLE, 8'd0, 8'hFF);    // below off threshold, fan stops
      send_request(OPC_SAMPLE, 8'd255, 8'h00);  // map saturates high, above max speed
      send_request(OPC_SAMPLE, 8'd45, 8'h00);   // exactly at on threshold
      send_request(OPC_SAMPLE, 8'd80, 8'h00);   // at max temperature, full speed
      send_request(OPC_SAMPLE, 8'd81, 8'h00);   // change smaller than sensitivity
      send_request(OPC_SAMPLE, 8'd42, 8'h00);   // inside the hysteresis band
      send_request(OPC_SAMPLE, 8'd40, 8'h00);   // exactly at off threshold
      send_request(OPC_SPEED, 8'd0, 8'd255);    // manual speed above max
      send_request(OPC_SPEED, 8'd255, 8'd0);    // manual fan off
      send_request(OPC_SPEED, 8'd0, 8'd150);    // manual speed at max
      send_request(OPC_SPEED, 8'hAA, 8'h55);

      // manual mode: samples leave the target alone
      settle();
      csr_write(CSR_MANUAL_OVERRIDE, 8'd1);
      send_request(OPC_SAMPLE, 8'd0, 8'h00);
      send_request(OPC_SAMPLE, 8'd255, 8'h00);
      send_request(OPC_SPEED, 8'd0, 8'd77);

      // equal temperature limits map straight to max speed
      settle();
      csr_write(CSR_MANUAL_OVERRIDE, 8'd0);
      csr_write(CSR_ON_THRESHOLD, 8'd100);
      csr_write(CSR_MAX_TEMPERATURE, 8'd100);
      csr_write(CSR_SPEED_MAX, 8'd200);
      send_request(OPC_SAMPLE, 8'd100, 8'h00);
      send_request(OPC_SAMPLE, 8'd255, 8'h00);

      // inverted speed span: map saturates low, min speed above max
      settle();
      csr_write(CSR_ON_THRESHOLD, 8'd10);
      csr_write(CSR_MAX_TEMPERATURE, 8'd20);
      csr_write(CSR_SPEED_MIN, 8'd255);
      csr_write(CSR_SPEED_MAX, 8'd0);
      csr_write(CSR_SENSITIVITY, 8'd0);
      csr_write(CSR_OFF_THRESHOLD, 8'd0);
      send_request(OPC_SAMPLE, 8'd200, 8'h00);
      send_request(OPC_SAMPLE, 8'd10, 8'h00);

      // full scale, sensitivity at its largest
      settle();
      csr_write(CSR_ON_THRESHOLD, 8'd0);
      csr_write(CSR_MAX_TEMPERATURE, 8'd1);
      csr_write(CSR_SPEED_MIN, 8'd0);
      csr_write(CSR_SPEED_MAX, 8'd255);
      csr_write(CSR_SENSITIVITY, 8'd255);
      csr_write(CSR_OFF_THRESHOLD, 8'd255);
      send_request(OPC_SAMPLE, 8'd0, 8'h00);
      send_request(OPC_SAMPLE, 8'd255, 8'h00);
      send_request(OPC_SAMPLE, 8'd128, 8'h00);

      // ---- random phases, each with its own register setting ----
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         if (phase == 0) begin
            on_v = 0; off_v = 0; maxt_v = 0; sens_v = 0; smin_v = 0; smax_v = 0;
            man_v = 0;
         end else if (phase == 1) begin
            on_v = 255; off_v = 255; maxt_v = 255; sens_v = 255; smin_v = 255;
            smax_v = 255; man_v = 0;
         end else if ($urandom_range(0, 4) == 0) begin
            // anything goes, including max temperature below on threshold
            on_v   = $urandom_range(0, 255);
            off_v  = $urandom_range(0, 255);
            maxt_v = $urandom_range(0, 255);
            sens_v = $urandom_range(0, 255);
            smin_v = $urandom_range(0, 255);
            smax_v = $urandom_range(0, 255);
            man_v  = int'($urandom_range(0, 3) == 0);
         end else begin
            // a usable thermal profile so the hysteresis loop gets exercised
            off_v  = $urandom_range(0, 200);
            on_v   = off_v + $urandom_range(0, 40);
            maxt_v = ($urandom_range(0, 7) == 0) ? on_v : on_v + $urandom_range(1, 80);
            if (maxt_v > 255) maxt_v = 255;
            sens_v = $urandom_range(0, 6);
            smin_v = $urandom_range(0, 120);
            smax_v = smin_v + $urandom_range(0, 135);
            man_v  = int'($urandom_range(0, 7) == 0);
         end
         csr_write(CSR_ON_THRESHOLD, on_v[7:0]);
         csr_write(CSR_OFF_THRESHOLD, off_v[7:0]);
         csr_write(CSR_MAX_TEMPERATURE, maxt_v[7:0]);
         csr_write(CSR_SENSITIVITY, sens_v[7:0]);
         csr_write(CSR_SPEED_MIN, smin_v[7:0]);
         csr_write(CSR_SPEED_MAX, smax_v[7:0]);
         csr_write(CSR_MANUAL_OVERRIDE, man_v[7:0]);
         cur = $urandom_range(0, 255);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // mostly a drifting temperature, with jumps and threshold hits
            pick = $urandom_range(0, 99);
            if (pick < 65) cur = cur + $urandom_range(0, 16) - 8;
            else if (pick < 80) cur = $urandom_range(0, 255);
            else if (pick < 90) cur = on_v + $urandom_range(0, 4) - 2;
            else cur = off_v + $urandom_range(0, 4) - 2;
            if (cur < 0) cur = 0;
            if (cur > 255) cur = 255;
            if ($urandom_range(0, 99) < 12) begin
               sval = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, smax_v));
               send_request(OPC_SPEED, 8'($urandom_range(0, 255)), sval);
            end else begin
               send_request(OPC_SAMPLE, cur[7:0], 8'($urandom_range(0, 255)));
            end
            // now and then hold off until the block has fully drained
            if ($urandom_range(0, 149) == 0) drain();
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (board.errors == 0) begin
         $display("PASS fan_speed_hysteresis_control");
      end else begin
         $display("FAIL fan_speed_hysteresis_control");
      end
      $finish;
   end

endmodule
